>>> sv/assert_macros.svh
// Concurrent assertion helpers; clk and arst_n must be visible at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define LFWW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included
`define LFWW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> sv/lfww_pkg.sv
package lfww_pkg;

	localparam int MAX_WRAP  = 63;
	localparam int WIN_DEPTH = MAX_WRAP + 1;
	localparam int WRAP_W    = $clog2(WIN_DEPTH);
	localparam int CNT_W     = WRAP_W + 1;
	localparam int RAM_DEPTH = 2 * WIN_DEPTH;
	localparam int PTR_W     = $clog2(RAM_DEPTH);
	localparam int CHAR_W    = 8;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	localparam logic [WRAP_W-1:0] WRAP_RESET = WRAP_W'(40);
	localparam logic [WRAP_W-1:0] WRAP_MIN   = WRAP_W'(2);

	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;

	// One command per input that produces output
	typedef struct packed {
		logic [PTR_W-1:0]  start;
		logic [CNT_W-1:0]  n;
		logic [WRAP_W-1:0] wrap;
		logic              scan;
		logic              hyphen;
		logic              blank;
	} cmd_t;

	// Fold point found by the back end's blank scan
	typedef struct packed {
		logic              vld;
		logic              found;
		logic [WRAP_W-1:0] pos;
	} fb_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
		return (ch == CH_SPACE) || (ch == CH_TAB);
	endfunction

endpackage

>>> sv/lfww_if.sv
interface lfww_in_if;
	logic                        valid;
	logic                        ready;
	logic [lfww_pkg::CHAR_W-1:0] in_char;

	modport source(output valid, output in_char, input ready);
	modport sink(input valid, input in_char, output ready);
endinterface

interface lfww_out_if;
	logic                        valid;
	logic                        ready;
	logic [lfww_pkg::CHAR_W-1:0] out_char;
	logic                        last_of_run;

	modport source(output valid, output out_char, output last_of_run, input ready);
	modport sink(input valid, input out_char, input last_of_run, output ready);
endinterface

>>> sv/line_fold_word_wrap_top.sv
// Channel   Dir   Payload                   Beat when
// feed      in    in_char[7:0]              feed.valid & feed.ready
// lines     out   out_char[7:0], last_of_run lines.valid & lines.ready
// cfg       in    cfg_wdata[5:0] (column)   cfg_we
//
// A byte is taken whenever the command queue and the character RAM have
// room and no blank search is pending. Each output byte of text is read
// through the RAM read port; the back end adds the hyphen and the line
// break itself. After the column is lowered below the window length, a
// fold may need a blank search in memory, during which input is held.
// Reset is asynchronous: empty window, column 40; RAM is not cleared.
module line_fold_word_wrap_top (
	input  logic                        clk,
	input  logic                        arst_n,
	lfww_in_if.sink                     feed,
	lfww_out_if.source                  lines,
	input  logic                        cfg_we,
	input  logic [lfww_pkg::WRAP_W-1:0] cfg_wdata
);
	import lfww_pkg::*;

	logic              q_push, q_pop, q_full, q_empty;
	cmd_t              q_din, q_dout;
	fb_t               fb;
	logic [PTR_W-1:0]  rel_ptr;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr, ram_raddr;
	logic [CHAR_W-1:0] ram_wdata, ram_rdata;

	lfww_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rel_ptr   (rel_ptr),
		.fb        (fb),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_din),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	lfww_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	lfww_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lfww_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_dout),
		.q_pop     (q_pop),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.fb        (fb),
		.rel_ptr   (rel_ptr),
		.lines     (lines)
	);
endmodule

>>> sv/lfww_ram.sv
module lfww_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/lfww_cmd_fifo.sv
module lfww_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lfww_pkg::cmd_t   din,
	input  logic             pop,
	output lfww_pkg::cmd_t   dout,
	output logic             full,
	output logic             empty
);
	import lfww_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
		end
	end
endmodule

>>> sv/lfww_front.sv
module lfww_front (
	input  logic                        clk,
	input  logic                        arst_n,
	lfww_in_if.sink                     feed,
	input  logic                        cfg_we,
	input  logic [lfww_pkg::WRAP_W-1:0] cfg_wdata,
	input  logic [lfww_pkg::PTR_W-1:0]  rel_ptr,
	input  lfww_pkg::fb_t               fb,
	input  logic                        q_full,
	output logic                        q_push,
	output lfww_pkg::cmd_t              q_cmd,
	output logic                        ram_we,
	output logic [lfww_pkg::PTR_W-1:0]  ram_waddr,
	output logic [lfww_pkg::CHAR_W-1:0] ram_wdata
);
	import lfww_pkg::*;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_WAIT = 1'b1;

	logic              state_q, state_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [WRAP_W-1:0] lb_q, lb_d;
	logic              lb_vld_q, lb_vld_d;
	logic [WRAP_W-1:0] wrap_q;

	logic [WRAP_W-1:0] eff_w;
	logic [PTR_W-1:0]  wr_ptr;
	logic [PTR_W-1:0]  gap;
	logic              acc, is_nl, app, fold, lb_hit, lb_far;
	logic [CNT_W-1:0]  cnt1;
	logic [WRAP_W-1:0] lb1;
	logic              lb1_vld;
	logic              drop;
	logic [CNT_W-1:0]  k;
	logic [CNT_W-1:0]  base_cnt;
	logic [WRAP_W-1:0] base_lb;
	logic              base_vld;

	assign eff_w  = (wrap_q < WRAP_MIN) ? WRAP_MIN : wrap_q;
	assign wr_ptr = head_q + PTR_W'(cnt_q);
	// slots from rel_ptr up to wr_ptr are still owed to the back end
	assign gap    = wr_ptr - rel_ptr;

	assign feed.ready = (state_q == ST_RUN) && !q_full && (gap != '1);
	assign acc        = feed.valid && feed.ready;
	assign is_nl      = (feed.in_char == CH_NL);
	assign app        = (cnt_q < CNT_W'(WIN_DEPTH));
	assign cnt1       = cnt_q + CNT_W'(app);

	// highest blank in the window, tracked as bytes arrive
	assign lb1_vld = (app && is_blank(feed.in_char)) ? 1'b1 : lb_vld_q;
	assign lb1     = (app && is_blank(feed.in_char)) ? cnt_q[WRAP_W-1:0] : lb_q;

	assign fold   = (cnt1 > CNT_W'(eff_w));
	assign lb_hit = lb1_vld && (lb1 != '0) && (lb1 <= eff_w);
	// last blank beyond the column: an earlier blank must be searched in memory
	assign lb_far = lb1_vld && (lb1 > eff_w);

	assign ram_we    = acc && !is_nl && app;
	assign ram_waddr = wr_ptr;
	assign ram_wdata = feed.in_char;

	always_comb begin
		q_cmd.start  = head_q;
		q_cmd.wrap   = eff_w;
		q_cmd.n      = CNT_W'(eff_w) - CNT_W'(1);
		q_cmd.scan   = 1'b0;
		q_cmd.hyphen = 1'b0;
		q_cmd.blank  = 1'b0;
		if (is_nl) begin
			q_cmd.n = cnt_q;
		end else if (lb_hit) begin
			q_cmd.n     = CNT_W'(lb1);
			q_cmd.blank = 1'b1;
		end else if (lb_far) begin
			q_cmd.scan = 1'b1;
		end else begin
			q_cmd.hyphen = 1'b1;
		end
	end

	assign q_push = acc && (is_nl || fold);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		cnt_d    = cnt_q;
		lb_d     = lb_q;
		lb_vld_d = lb_vld_q;
		drop     = 1'b0;
		k        = '0;
		base_cnt = cnt_q;
		base_lb  = lb_q;
		base_vld = lb_vld_q;
		if (state_q == ST_RUN && acc) begin
			if (is_nl) begin
				head_d   = wr_ptr;
				cnt_d    = '0;
				lb_vld_d = 1'b0;
			end else begin
				base_cnt = cnt1;
				base_lb  = lb1;
				base_vld = lb1_vld;
				cnt_d    = cnt1;
				lb_d     = lb1;
				lb_vld_d = lb1_vld;
				if (fold && lb_far) begin
					state_d = ST_WAIT;
				end else if (fold) begin
					drop = 1'b1;
					k    = lb_hit ? CNT_W'(lb1) + CNT_W'(1) : CNT_W'(eff_w) - CNT_W'(1);
				end
			end
		end else if (state_q == ST_WAIT && fb.vld) begin
			state_d = ST_RUN;
			drop    = 1'b1;
			k       = fb.found ? CNT_W'(fb.pos) + CNT_W'(1) : CNT_W'(eff_w) - CNT_W'(1);
		end
		if (drop) begin
			head_d = head_q + PTR_W'(k);
			cnt_d  = base_cnt - k;
			if (base_vld && (CNT_W'(base_lb) >= k)) begin
				lb_d     = base_lb - k[WRAP_W-1:0];
				lb_vld_d = 1'b1;
			end else begin
				lb_vld_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			head_q   <= '0;
			cnt_q    <= '0;
			lb_q     <= '0;
			lb_vld_q <= 1'b0;
			wrap_q   <= WRAP_RESET;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			cnt_q    <= cnt_d;
			lb_q     <= lb_d;
			lb_vld_q <= lb_vld_d;
			if (cfg_we) begin
				wrap_q <= cfg_wdata;
			end
		end
	end
endmodule

>>> sv/lfww_back.sv
module lfww_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  lfww_pkg::cmd_t              q_cmd,
	output logic                        q_pop,
	output logic [lfww_pkg::PTR_W-1:0]  ram_raddr,
	input  logic [lfww_pkg::CHAR_W-1:0] ram_rdata,
	output lfww_pkg::fb_t               fb,
	output logic [lfww_pkg::PTR_W-1:0]  rel_ptr,
	lfww_out_if.source                  lines
);
	import lfww_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_SUF  = 2'd3;

	logic [1:0]        state_q;
	logic [PTR_W-1:0]  start_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  e_q;
	logic [WRAP_W-1:0] w_q;
	logic              hyph_q;
	logic              blank_q;
	logic [WRAP_W-1:0] idx_q;
	logic              scan_more_q;
	logic [PTR_W-1:0]  rel_q;

	// read stage, aligned with the registered RAM data
	logic              vld_s1;
	logic              scan_s1;
	logic              cst_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic [WRAP_W-1:0] idx_s1;

	logic [CHAR_W-1:0] ob_char_q [2];
	logic              ob_last_q [2];
	logic              ob_wr_q;
	logic              ob_rd_q;
	logic [1:0]        ob_cnt_q;

	logic              issue, is_scan, is_cst, is_last;
	logic [CHAR_W-1:0] cst_char;
	logic              ob_push, ob_pop, can;
	logic [2:0]        occ;
	logic              scan_ret, ret_blank;

	assign ob_push = vld_s1 && !scan_s1;
	assign ob_pop  = lines.valid && lines.ready;
	// credit check: bytes held plus byte in the read stage
	assign occ     = 3'(ob_cnt_q) + 3'(ob_push);
	assign can     = (occ < 3'd2) || (occ == 3'd2 && ob_pop);

	assign lines.valid       = (ob_cnt_q != '0);
	assign lines.out_char    = ob_char_q[ob_rd_q];
	assign lines.last_of_run = ob_last_q[ob_rd_q];

	assign scan_ret  = (state_q == ST_SCAN) && vld_s1 && scan_s1;
	assign ret_blank = is_blank(ram_rdata);
	assign fb.vld    = scan_ret && (ret_blank || idx_s1 == WRAP_W'(1));
	assign fb.found  = ret_blank;
	assign fb.pos    = idx_s1;

	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign rel_ptr = rel_q;

	always_comb begin
		issue     = 1'b0;
		is_scan   = 1'b0;
		is_cst    = 1'b0;
		is_last   = 1'b0;
		cst_char  = CH_NL;
		ram_raddr = start_q + PTR_W'(e_q);
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SCAN: begin
				issue     = scan_more_q && !fb.vld;
				is_scan   = 1'b1;
				ram_raddr = start_q + PTR_W'(idx_q);
			end
			ST_EMIT: begin
				issue = (e_q != n_q) && can;
			end
			ST_SUF: begin
				issue    = can;
				is_cst   = 1'b1;
				cst_char = hyph_q ? CH_HYPHEN : CH_NL;
				is_last  = !hyph_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		scan_s1 <= is_scan;
		cst_s1  <= is_cst;
		char_s1 <= cst_char;
		last_s1 <= is_last;
		idx_s1  <= idx_q;
		if (ob_push) begin
			ob_char_q[ob_wr_q] <= cst_s1 ? char_s1 : ram_rdata;
			ob_last_q[ob_wr_q] <= last_s1;
		end
		if (q_pop) begin
			start_q <= q_cmd.start;
			n_q     <= q_cmd.n;
			w_q     <= q_cmd.wrap;
			hyph_q  <= q_cmd.hyphen;
			blank_q <= q_cmd.blank;
			idx_q   <= q_cmd.wrap;
			e_q     <= '0;
		end else if (fb.vld) begin
			e_q <= '0;
			if (fb.found) begin
				n_q     <= CNT_W'(fb.pos);
				blank_q <= 1'b1;
				hyph_q  <= 1'b0;
			end else begin
				n_q     <= CNT_W'(w_q) - CNT_W'(1);
				blank_q <= 1'b0;
				hyph_q  <= 1'b1;
			end
		end else if (issue) begin
			unique case (state_q)
				ST_SCAN: idx_q <= idx_q - WRAP_W'(1);
				ST_EMIT: e_q <= e_q + CNT_W'(1);
				ST_SUF:  hyph_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_more_q <= 1'b0;
			rel_q       <= '0;
			vld_s1      <= 1'b0;
			ob_wr_q     <= 1'b0;
			ob_rd_q     <= 1'b0;
			ob_cnt_q    <= '0;
		end else begin
			vld_s1   <= issue;
			ob_cnt_q <= ob_cnt_q + 2'(ob_push) - 2'(ob_pop);
			if (ob_push) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q     <= q_cmd.scan ? ST_SCAN : ST_EMIT;
						scan_more_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (fb.vld) begin
						state_q <= ST_EMIT;
					end else if (issue) begin
						scan_more_q <= (idx_q != WRAP_W'(1));
					end
				end
				ST_EMIT: begin
					if (e_q == n_q) begin
						state_q <= ST_SUF;
					end
				end
				ST_SUF: begin
					if (issue && !hyph_q) begin
						state_q <= ST_IDLE;
						// slots up to the new line start may now be reused
						rel_q   <= start_q + PTR_W'(n_q) + PTR_W'(blank_q);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> sv/lfww_checker.sv
`include "assert_macros.svh"

module lfww_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lfww_pkg::CHAR_W-1:0] out_char,
	input logic                        last_of_run
);
	import lfww_pkg::*;

	logic stall;

	assign stall = out_valid && !out_ready;

	`LFWW_ASSERT(a_valid_held, stall |=> out_valid, "lines.valid dropped")
	`LFWW_ASSERT(a_beat_held, stall |=> $stable({out_char, last_of_run}), "stalled beat changed")
	// every run closes with the line break
	`LFWW_ASSERT(a_run_ends_nl, out_valid && last_of_run |-> out_char == CH_NL, "run ends without newline")
	`LFWW_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> !out_valid, "output valid during reset")
endmodule

bind line_fold_word_wrap_top lfww_checker u_lfww_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (lines.valid),
	.out_ready   (lines.ready),
	.out_char    (lines.out_char),
	.last_of_run (lines.last_of_run)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import lfww_pkg::*;

	typedef logic [CHAR_W-1:0] char_t;
	typedef struct packed {
		char_t ch;
		logic  last;
	} text_beat_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [WRAP_W-1:0] cfg_wdata;

	lfww_in_if  feed();
	lfww_out_if lines();

	line_fold_word_wrap_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.lines     (lines),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// line buffer mirror and the column in force
	char_t             line_win [WIN_DEPTH];
	int                line_len;
	logic [WRAP_W-1:0] fold_col;
	text_beat_t        folded_text_q[$];

	int n_fail;
	int feed_idle_pct;
	int drain_stall_pct;
	int drain_hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void predict_fold(input char_t c);
		text_beat_t run[$];
		int         w;
		int         p;
		int         k;
		int         i;
		w = (fold_col < WRAP_MIN) ? int'(WRAP_MIN) : int'(fold_col);
		if (c == CH_NL) begin
			for (i = 0; i < line_len; i++)
				run.push_back('{line_win[i], 1'b0});
			run.push_back('{CH_NL, 1'b0});
			line_len = 0;
		end else begin
			if (line_len < WIN_DEPTH) begin
				line_win[line_len] = c;
				line_len++;
			end
			if (line_len >= w + 1) begin
				// rightmost blank in columns 1..w; column 0 never counts
				p = 0;
				for (i = w; i >= 1; i--) begin
					if (line_win[i] == CH_SPACE || line_win[i] == CH_TAB) begin
						p = i;
						break;
					end
				end
				if (p > 0) begin
					for (i = 0; i < p; i++)
						run.push_back('{line_win[i], 1'b0});
					run.push_back('{CH_NL, 1'b0});
					k = p + 1;
				end else begin
					for (i = 0; i < w - 1; i++)
						run.push_back('{line_win[i], 1'b0});
					run.push_back('{CH_HYPHEN, 1'b0});
					run.push_back('{CH_NL, 1'b0});
					k = w - 1;
				end
				for (i = 0; i + k < line_len; i++)
					line_win[i] = line_win[i + k];
				line_len = (k >= line_len) ? 0 : line_len - k;
			end
		end
		if (run.size() > 0) begin
			run[run.size() - 1].last = 1'b1;
			foreach (run[j])
				folded_text_q.push_back(run[j]);
		end
	endfunction

	function automatic char_t rand_text_char();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return char_t'($urandom_range(122, 97));
		else if (r < 70)
			return CH_SPACE;
		else if (r < 76)
			return CH_TAB;
		else if (r < 84)
			return CH_NL;
		else if (r < 88)
			return CH_HYPHEN;
		else
			return char_t'($urandom_range(255));
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_byte(input char_t c);
		while ($urandom_range(99) < feed_idle_pct) begin
			feed.valid <= 1'b0;
			@(negedge clk);
		end
		feed.valid   <= 1'b1;
		feed.in_char <= c;
		@(posedge clk);
		while (!feed.ready)
			@(posedge clk);
		predict_fold(c);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		int guard;
		feed.valid <= 1'b0;
		guard = 0;
		while (folded_text_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (folded_text_q.size() != 0) begin
			$display("%0t: %0d output bytes never arrived", $time, folded_text_q.size());
			n_fail++;
			folded_text_q.delete();
		end
		// bytes with no output may still be in flight; let the back end settle
		repeat (150) @(negedge clk);
	endtask

	task automatic write_column(input logic [WRAP_W-1:0] col);
		cfg_we    <= 1'b1;
		cfg_wdata <= col;
		@(posedge clk);
		fold_col = col;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_column();
		send_byte(char_t'("a"));
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0D);
		send_byte(CH_TAB);
		send_byte(CH_SPACE);
		send_byte(CH_HYPHEN);
		send_byte(CH_NL);
		send_byte(CH_NL);
		wait_idle();
	endtask

	// columns 0 and 1 both behave as 2
	task automatic test_narrow_columns();
		write_column('0);
		send_byte(char_t'("a"));
		send_byte(char_t'("b"));
		send_byte(char_t'("c"));
		send_byte(char_t'("d"));
		wait_idle();
		write_column(WRAP_W'(1));
		send_byte(char_t'("x"));
		send_byte(CH_SPACE);
		send_byte(char_t'("y"));
		send_byte(CH_NL);
		wait_idle();
	endtask

	task automatic test_widest_column();
		write_column(WRAP_W'(MAX_WRAP));
		for (int i = 0; i < 64; i++)
			send_byte(char_t'($urandom_range(126, 33)));
		wait_idle();
	endtask

	// long pending line, then a much narrower column: bytes fold it until a newline flushes it
	task automatic test_column_lowered();
		send_byte(CH_NL);
		for (int i = 0; i < 16; i++)
			send_byte(char_t'($urandom_range(126, 33)));
		wait_idle();
		write_column(WRAP_W'(3));
		for (int i = 0; i < 6; i++)
			send_byte(rand_text_char());
		wait_idle();
	endtask

	task automatic test_random_text(input int n, input int idle_pct, input int stall_pct,
			input logic [WRAP_W-1:0] col);
		write_column(col);
		feed_idle_pct   = idle_pct;
		drain_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_byte(rand_text_char());
		wait_idle();
		feed_idle_pct   = 0;
		drain_stall_pct = 0;
	endtask

	// sink holds off long enough that the block fills and stops taking bytes
	task automatic test_output_backpressure();
		write_column(WRAP_W'(8));
		@(posedge clk);
		drain_hold_cycles = 400;
		@(negedge clk);
		for (int i = 0; i < 20; i++)
			send_byte((i % 4 == 3) ? CH_NL : char_t'($urandom_range(122, 97)));
		wait_idle();
	endtask

	// output side: ready changes on the falling edge
	initial begin
		forever begin
			@(negedge clk);
			if (drain_hold_cycles > 0) begin
				lines.ready <= 1'b0;
				drain_hold_cycles--;
			end else begin
				lines.ready <= ($urandom_range(99) >= drain_stall_pct);
			end
		end
	end

	initial begin
		text_beat_t got;
		text_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && lines.valid && lines.ready) begin
				got.ch   = lines.out_char;
				got.last = lines.last_of_run;
				// let the sender book the byte accepted on this same edge
				#1;
				if (folded_text_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got out_char %h last_of_run %b",
						$time, got.ch, got.last);
					n_fail++;
				end else begin
					want = folded_text_q.pop_front();
					if (got.ch !== want.ch) begin
						$display("%0t: out_char expected %h got %h", $time, want.ch, got.ch);
						n_fail++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_of_run expected %b got %b", $time, want.last,
							got.last);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin
		n_fail            = 0;
		line_len          = 0;
		fold_col          = WRAP_RESET;
		feed_idle_pct     = 0;
		drain_stall_pct   = 0;
		drain_hold_cycles = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		feed.valid    <= 1'b0;
		feed.in_char  <= '0;
		lines.ready   <= 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_column();
		test_narrow_columns();
		test_widest_column();
		test_column_lowered();
		test_random_text(8, 0, 0, WRAP_RESET);
		test_random_text(8, 49, 0, WRAP_MIN);
		test_random_text(8, 0, 49, WRAP_W'($urandom_range(62, 3)));
		test_random_text(8, 17, 17, WRAP_W'($urandom_range(62, 2)));
		test_output_backpressure();

		if (n_fail == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> line_fold_word_wrap_top.f
+incdir+sv
sv/lfww_pkg.sv
sv/lfww_if.sv
sv/lfww_ram.sv
sv/lfww_cmd_fifo.sv
sv/lfww_front.sv
sv/lfww_back.sv
sv/line_fold_word_wrap_top.sv
sv/lfww_checker.sv
tb/tb.sv
